[rtl/cco_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capsule overlap test package
// Widths, beat layout, case codes and carried record types shared by the
// capsule overlap pipeline and its divider.
// ----------------------------------------------------------------------------
package cco_pkg;

	// Number formats.
	localparam int COORD_BITS      = 20;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
	localparam int RAD_W           = COORD_BITS - 1;
	localparam int RSUM_W          = RAD_W + 1;
	localparam int RSQ_W           = 2 * RSUM_W;
	localparam int LIM_W           = 16;

	// Intermediate widths.
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DOT_W   = 2 * DIFF_W + 2;
	localparam int SPLIT   = DOT_W / 2;
	localparam int PART_W  = DOT_W + SPLIT + 2;
	localparam int WIDE_W  = 2 * DOT_W + 2;
	localparam int DIV_W   = WIDE_W;
	localparam int DIV_LAT = RATIO_FRAC_BITS + 1;
	localparam int TNUM_W  = DOT_W + RATIO_W + 2;
	localparam int SPR_W   = DIFF_W + RATIO_W + 1;
	localparam int DELTA_W = DIFF_W + RATIO_W + 3;
	localparam int DSPLIT  = (DELTA_W + 1) / 2;
	localparam int SQP_W   = DELTA_W + DSPLIT + 1;
	localparam int SQ_W    = 2 * DELTA_W + 2;

	// Input beat layout.
	localparam int PT_W    = 3 * COORD_BITS;
	localparam int FS_LO   = 0;
	localparam int FE_LO   = FS_LO + PT_W;
	localparam int SS_LO   = FE_LO + PT_W;
	localparam int SE_LO   = SS_LO + PT_W;
	localparam int R1_LO   = SE_LO + PT_W;
	localparam int R2_LO   = R1_LO + RAD_W;
	localparam int IN_BITS = R2_LO + RAD_W;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W   = 8;

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

	// Which segments are point-like.
	typedef enum logic [1:0] {
		KIND_GEN    = 2'd0,
		KIND_FIRST  = 2'd1,
		KIND_SECOND = 2'd2,
		KIND_BOTH   = 2'd3
	} kind_t;

	// Where the derived second fraction landed.
	typedef enum logic [1:0] {
		SEL_MID  = 2'd0,
		SEL_LOW  = 2'd1,
		SEL_HIGH = 2'd2
	} sel_t;

	// Segment directions, offset between starts and radius sum.
	typedef struct packed {
		logic [2:0][DIFF_W-1:0] d1;
		logic [2:0][DIFF_W-1:0] d2;
		logic [2:0][DIFF_W-1:0] rv;
		logic [RSUM_W-1:0]      rsum;
	} geo_t;

	// Dot products.
	typedef struct packed {
		logic signed [DOT_W-1:0] a;
		logic signed [DOT_W-1:0] e;
		logic signed [DOT_W-1:0] f;
		logic signed [DOT_W-1:0] c;
		logic signed [DOT_W-1:0] b;
	} dots_t;

	// Record that rides beside the first divider.
	typedef struct packed {
		kind_t kind;
		dots_t dots;
		geo_t  geo;
	} side1_t;

	// Record that rides beside the second divider.
	typedef struct packed {
		kind_t              kind;
		sel_t               sel;
		logic [RATIO_W-1:0] q1;
		geo_t               geo;
	} side2_t;

endpackage
`default_nettype wire

[rtl/cco_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clamped fraction divider
// Pipelined restoring divider giving floor(num / den) in unsigned
// Q1.RATIO_FRAC_BITS clamped to [0, 1], one quotient bit per stage.
// ----------------------------------------------------------------------------
module cco_div import cco_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DIV_W-1:0]  num,
	input  logic signed [DIV_W-1:0]  den,
	output logic [RATIO_W-1:0]       quo
);

	logic [DIV_W-1:0]           rem_q  [0:RATIO_FRAC_BITS];
	logic [DIV_W-1:0]           den_q  [0:RATIO_FRAC_BITS];
	logic [RATIO_FRAC_BITS-1:0] quo_q  [0:RATIO_FRAC_BITS];
	logic                       zero_q [0:RATIO_FRAC_BITS];
	logic                       one_q  [0:RATIO_FRAC_BITS];
	logic [DIV_W-1:0]           rem_dbl [0:RATIO_FRAC_BITS-1];

	// Doubled partial remainder of each stage.
	always_comb begin
		for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
			rem_dbl[i] = {rem_q[i][DIV_W-2:0], 1'b0};
		end
	end

	// Entry stage decides the clamped cases; each later stage adds one bit.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= num;
			den_q[0]  <= den;
			quo_q[0]  <= '0;
			zero_q[0] <= num[DIV_W-1] || (num == '0);
			one_q[0]  <= (num >= den);
			for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
				den_q[i+1]  <= den_q[i];
				zero_q[i+1] <= zero_q[i];
				one_q[i+1]  <= one_q[i];
				if (rem_dbl[i] >= den_q[i]) begin
					rem_q[i+1] <= rem_dbl[i] - den_q[i];
					quo_q[i+1] <= {quo_q[i][RATIO_FRAC_BITS-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= rem_dbl[i];
					quo_q[i+1] <= {quo_q[i][RATIO_FRAC_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Apply the clamp decided at entry.
	always_comb begin
		if (zero_q[RATIO_FRAC_BITS]) begin
			quo = '0;
		end else if (one_q[RATIO_FRAC_BITS]) begin
			quo = RATIO_ONE;
		end else begin
			quo = {1'b0, quo_q[RATIO_FRAC_BITS]};
		end
	end

endmodule
`default_nettype wire

[rtl/capsule_capsule_overlap_test_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Capsule-capsule overlap test
// Finds the closest points of two 3D segments by the clamped segment-segment
// method and flags a hit when they lie within the sum of the capsule radii.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on s_axis carries one capsule pair: four Q12.8 points
//   and two Q11.8 radii. Each output beat on m_axis carries one hit flag.
//   Results leave in the order the pairs arrived, one per input beat.
//   An input beat passes 14 arithmetic stages plus two 17-stage dividers,
//   one for the first fraction and one for the second fraction or the
//   re-clamped first one. Throughput is one pair per cycle while the
//   output is not stalled; every stage is a register stage. The cfg
//   channel writes the degenerate length limit; cfg_ready is always
//   high, and it must only be written while no pair is in flight.
//   Reset clears all stage valid bits and sets the limit to zero.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops; nothing is lost or
//   repeated, and flow resumes in the same cycle that tready returns.
// ----------------------------------------------------------------------------
module capsule_capsule_overlap_test_top import cco_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Fields from bit 0: first_start, first_end, second_start, second_end,
	// first_radius, second_radius, zero fill.
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// Fields from bit 0: hit, zero fill.
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [LIM_W-1:0] cfg_data,
	input  logic             cfg_valid,
	output logic             cfg_ready
);

	logic             en;
	logic [LIM_W-1:0] lim_q;

	// Valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14;
	logic dv1_q [0:DIV_LAT-1];
	logic dv2_q [0:DIV_LAT-1];

	// Payload stages.
	geo_t                     geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s10;
	logic signed [PROD_W-1:0] pa_s2 [3];
	logic signed [PROD_W-1:0] pe_s2 [3];
	logic signed [PROD_W-1:0] pf_s2 [3];
	logic signed [PROD_W-1:0] pc_s2 [3];
	logic signed [PROD_W-1:0] pb_s2 [3];
	dots_t                    dots_s3, dots_s4, dots_s5;
	kind_t                    kind_s4, kind_s5;
	logic signed [PART_W-1:0] ae_lo_s4, ae_hi_s4, bb_lo_s4, bb_hi_s4;
	logic signed [PART_W-1:0] bf_lo_s4, bf_hi_s4, ce_lo_s4, ce_hi_s4;
	logic signed [WIDE_W-1:0] ae_s5, bsq_s5, bf_s5, ce_s5;
	logic signed [WIDE_W-1:0] denom;
	logic signed [WIDE_W-1:0] snum;
	logic signed [DIV_W-1:0]  n1_s6, den1_s6;
	side1_t                   side_s6, side_s7, side_s8;
	side1_t                   dl1_q [0:DIV_LAT-1];
	logic [RATIO_W-1:0]       q1, q1_s7, q1_s8;
	logic signed [TNUM_W-1:0] bs_s7, tnum_s8, tden_s8;
	logic                     t_low, t_high;
	logic signed [DIV_W-1:0]  n2_s9, den2_s9;
	side2_t                   side_s9;
	side2_t                   dl2_q [0:DIV_LAT-1];
	logic [RATIO_W-1:0]       q2;
	logic [RATIO_W-1:0]       s_fin, t_fin;
	logic signed [SPR_W-1:0]  ps_s10 [3];
	logic signed [SPR_W-1:0]  pt_s10 [3];
	logic signed [DELTA_W-1:0] dl_s11 [3];
	logic [RSUM_W-1:0]        rsum_s11;
	logic signed [SQP_W-1:0]  sq_lo_s12 [3];
	logic signed [SQP_W-1:0]  sq_hi_s12 [3];
	logic [RSQ_W-1:0]         rsq_s12, rsq_s13;
	logic [SQ_W-1:0]          sq_s13 [3];
	logic [SQ_W-1:0]          dist2;
	logic                     hit_s14;

	// The pipeline moves whenever the output register is free or drained.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = v_s14;
	assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, hit_s14};

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			lim_q <= cfg_data;
		end
	end

	// Valid bits advance together with the payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				dv1_q[i] <= 1'b0;
				dv2_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			dv1_q[0] <= v_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				dv1_q[i] <= dv1_q[i-1];
				dv2_q[i] <= dv2_q[i-1];
			end
			v_s7 <= dv1_q[DIV_LAT-1]; v_s8 <= v_s7; v_s9 <= v_s8;
			dv2_q[0] <= v_s9;
			v_s10 <= dv2_q[DIV_LAT-1];
			v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12; v_s14 <= v_s13;
		end
	end

	// Stage 1: unpack the points, form directions and the start offset.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				geo_s1.d1[k] <=
					DIFF_W'($signed(s_axis_tdata[FE_LO+k*COORD_BITS +: COORD_BITS])) -
					DIFF_W'($signed(s_axis_tdata[FS_LO+k*COORD_BITS +: COORD_BITS]));
				geo_s1.d2[k] <=
					DIFF_W'($signed(s_axis_tdata[SE_LO+k*COORD_BITS +: COORD_BITS])) -
					DIFF_W'($signed(s_axis_tdata[SS_LO+k*COORD_BITS +: COORD_BITS]));
				geo_s1.rv[k] <=
					DIFF_W'($signed(s_axis_tdata[FS_LO+k*COORD_BITS +: COORD_BITS])) -
					DIFF_W'($signed(s_axis_tdata[SS_LO+k*COORD_BITS +: COORD_BITS]));
			end
			geo_s1.rsum <= RSUM_W'(s_axis_tdata[R1_LO +: RAD_W]) +
				RSUM_W'(s_axis_tdata[R2_LO +: RAD_W]);
		end
	end

	// Stage 2: component products of the five dot products.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_s1;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= $signed(geo_s1.d1[k]) * $signed(geo_s1.d1[k]);
				pe_s2[k] <= $signed(geo_s1.d2[k]) * $signed(geo_s1.d2[k]);
				pf_s2[k] <= $signed(geo_s1.d2[k]) * $signed(geo_s1.rv[k]);
				pc_s2[k] <= $signed(geo_s1.d1[k]) * $signed(geo_s1.rv[k]);
				pb_s2[k] <= $signed(geo_s1.d1[k]) * $signed(geo_s1.d2[k]);
			end
		end
	end

	// Stage 3: sum the components.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3    <= geo_s2;
			dots_s3.a <= DOT_W'(pa_s2[0]) + DOT_W'(pa_s2[1]) + DOT_W'(pa_s2[2]);
			dots_s3.e <= DOT_W'(pe_s2[0]) + DOT_W'(pe_s2[1]) + DOT_W'(pe_s2[2]);
			dots_s3.f <= DOT_W'(pf_s2[0]) + DOT_W'(pf_s2[1]) + DOT_W'(pf_s2[2]);
			dots_s3.c <= DOT_W'(pc_s2[0]) + DOT_W'(pc_s2[1]) + DOT_W'(pc_s2[2]);
			dots_s3.b <= DOT_W'(pb_s2[0]) + DOT_W'(pb_s2[1]) + DOT_W'(pb_s2[2]);
		end
	end

	// Stage 4: classify the segments and form split partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4  <= geo_s3;
			dots_s4 <= dots_s3;
			if (dots_s3.a <= DOT_W'(lim_q) && dots_s3.e <= DOT_W'(lim_q)) begin
				kind_s4 <= KIND_BOTH;
			end else if (dots_s3.a <= DOT_W'(lim_q)) begin
				kind_s4 <= KIND_FIRST;
			end else if (dots_s3.e <= DOT_W'(lim_q)) begin
				kind_s4 <= KIND_SECOND;
			end else begin
				kind_s4 <= KIND_GEN;
			end
			ae_lo_s4 <= dots_s3.a * $signed({1'b0, dots_s3.e[SPLIT-1:0]});
			ae_hi_s4 <= dots_s3.a * $signed(dots_s3.e[DOT_W-1:SPLIT]);
			bb_lo_s4 <= dots_s3.b * $signed({1'b0, dots_s3.b[SPLIT-1:0]});
			bb_hi_s4 <= dots_s3.b * $signed(dots_s3.b[DOT_W-1:SPLIT]);
			bf_lo_s4 <= dots_s3.b * $signed({1'b0, dots_s3.f[SPLIT-1:0]});
			bf_hi_s4 <= dots_s3.b * $signed(dots_s3.f[DOT_W-1:SPLIT]);
			ce_lo_s4 <= dots_s3.c * $signed({1'b0, dots_s3.e[SPLIT-1:0]});
			ce_hi_s4 <= dots_s3.c * $signed(dots_s3.e[DOT_W-1:SPLIT]);
		end
	end

	// Stage 5: recombine the wide products.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5  <= geo_s4;
			dots_s5 <= dots_s4;
			kind_s5 <= kind_s4;
			ae_s5   <= WIDE_W'(ae_lo_s4) + (WIDE_W'(ae_hi_s4) <<< SPLIT);
			bsq_s5  <= WIDE_W'(bb_lo_s4) + (WIDE_W'(bb_hi_s4) <<< SPLIT);
			bf_s5   <= WIDE_W'(bf_lo_s4) + (WIDE_W'(bf_hi_s4) <<< SPLIT);
			ce_s5   <= WIDE_W'(ce_lo_s4) + (WIDE_W'(ce_hi_s4) <<< SPLIT);
		end
	end

	// Stage 6: pick the first division for each case.
	assign denom = ae_s5 - bsq_s5;
	assign snum  = bf_s5 - ce_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6.kind <= kind_s5;
			side_s6.dots <= dots_s5;
			side_s6.geo  <= geo_s5;
			case (kind_s5)
				KIND_GEN: begin
					if (denom == '0) begin
						n1_s6   <= '0;
						den1_s6 <= DIV_W'(1);
					end else begin
						n1_s6   <= snum;
						den1_s6 <= denom;
					end
				end
				KIND_FIRST: begin
					n1_s6   <= DIV_W'(dots_s5.f);
					den1_s6 <= DIV_W'(dots_s5.e);
				end
				KIND_SECOND: begin
					n1_s6   <= -DIV_W'(dots_s5.c);
					den1_s6 <= DIV_W'(dots_s5.a);
				end
				default: begin
					n1_s6   <= '0;
					den1_s6 <= DIV_W'(1);
				end
			endcase
		end
	end

	cco_div u_div1 (
		.clk (clk),
		.en  (en),
		.num (n1_s6),
		.den (den1_s6),
		.quo (q1)
	);

	// Records that travel beside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			dl1_q[0] <= side_s6;
			dl2_q[0] <= side_s9;
			for (int i = 1; i < DIV_LAT; i++) begin
				dl1_q[i] <= dl1_q[i-1];
				dl2_q[i] <= dl2_q[i-1];
			end
		end
	end

	// Stages 7 and 8: numerator and denominator of the second fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= dl1_q[DIV_LAT-1];
			q1_s7   <= q1;
			bs_s7   <= dl1_q[DIV_LAT-1].dots.b * $signed({1'b0, q1});
			side_s8 <= side_s7;
			q1_s8   <= q1_s7;
			tnum_s8 <= bs_s7 + (TNUM_W'(side_s7.dots.f) <<< RATIO_FRAC_BITS);
			tden_s8 <= TNUM_W'(side_s7.dots.e) <<< RATIO_FRAC_BITS;
		end
	end

	// Stage 9: clamp check and the second division.
	assign t_low  = tnum_s8 < 0;
	assign t_high = tnum_s8 > tden_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9.kind <= side_s8.kind;
			side_s9.q1   <= q1_s8;
			side_s9.geo  <= side_s8.geo;
			if (side_s8.kind != KIND_GEN) begin
				side_s9.sel <= SEL_MID;
				n2_s9       <= '0;
				den2_s9     <= DIV_W'(1);
			end else if (t_low) begin
				side_s9.sel <= SEL_LOW;
				n2_s9       <= -DIV_W'(side_s8.dots.c);
				den2_s9     <= DIV_W'(side_s8.dots.a);
			end else if (t_high) begin
				side_s9.sel <= SEL_HIGH;
				n2_s9       <= DIV_W'(side_s8.dots.b) - DIV_W'(side_s8.dots.c);
				den2_s9     <= DIV_W'(side_s8.dots.a);
			end else begin
				side_s9.sel <= SEL_MID;
				n2_s9       <= DIV_W'(tnum_s8);
				den2_s9     <= DIV_W'(tden_s8);
			end
		end
	end

	cco_div u_div2 (
		.clk (clk),
		.en  (en),
		.num (n2_s9),
		.den (den2_s9),
		.quo (q2)
	);

	// Final fractions for each case.
	always_comb begin
		case (dl2_q[DIV_LAT-1].kind)
			KIND_FIRST: begin
				s_fin = '0;
				t_fin = dl2_q[DIV_LAT-1].q1;
			end
			KIND_SECOND: begin
				s_fin = dl2_q[DIV_LAT-1].q1;
				t_fin = '0;
			end
			KIND_GEN: begin
				case (dl2_q[DIV_LAT-1].sel)
					SEL_LOW: begin
						s_fin = q2;
						t_fin = '0;
					end
					SEL_HIGH: begin
						s_fin = q2;
						t_fin = RATIO_ONE;
					end
					default: begin
						s_fin = dl2_q[DIV_LAT-1].q1;
						t_fin = q2;
					end
				endcase
			end
			default: begin
				s_fin = '0;
				t_fin = '0;
			end
		endcase
	end

	// Stages 10 to 14: closest-point difference, squared length, compare.
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s10 <= dl2_q[DIV_LAT-1].geo;
			for (int k = 0; k < 3; k++) begin
				ps_s10[k] <= $signed(dl2_q[DIV_LAT-1].geo.d1[k]) * $signed({1'b0, s_fin});
				pt_s10[k] <= $signed(dl2_q[DIV_LAT-1].geo.d2[k]) * $signed({1'b0, t_fin});
				dl_s11[k] <= (DELTA_W'($signed(geo_s10.rv[k])) <<< RATIO_FRAC_BITS) +
					DELTA_W'(ps_s10[k]) - DELTA_W'(pt_s10[k]);
				sq_lo_s12[k] <= dl_s11[k] * $signed({1'b0, dl_s11[k][DSPLIT-1:0]});
				sq_hi_s12[k] <= dl_s11[k] * $signed(dl_s11[k][DELTA_W-1:DSPLIT]);
				sq_s13[k] <= SQ_W'(SQ_W'(sq_lo_s12[k]) + (SQ_W'(sq_hi_s12[k]) <<< DSPLIT));
			end
			rsum_s11 <= geo_s10.rsum;
			rsq_s12  <= RSQ_W'(rsum_s11) * RSQ_W'(rsum_s11);
			rsq_s13  <= rsq_s12;
			hit_s14  <= dist2 <= SQ_W'({rsq_s13, {(2*RATIO_FRAC_BITS){1'b0}}});
		end
	end

	assign dist2 = sq_s13[0] + sq_s13[1] + sq_s13[2];

`ifndef SYNTHESIS
	// A beat is only taken while the pipeline is free to move.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> (!v_s14 || m_axis_tready))
		else $error("input beat accepted while pipeline is stalled");

	// The first fraction never leaves [0, 1].
	assert property (@(posedge clk) disable iff (!arst_n)
		dv1_q[DIV_LAT-1] |-> (q1 <= RATIO_ONE))
		else $error("first fraction out of range");

	// A stall freezes the stage after the first divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s14 && !m_axis_tready) |=> ($stable(v_s7) && $stable(bs_s7)))
		else $error("pipeline moved during a stall");

	// The radius sum rides along unchanged to the square stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s11) |=> (rsq_s12 == RSQ_W'($past(rsum_s11)) * RSQ_W'($past(rsum_s11))))
		else $error("radius square mismatch");
`endif

endmodule
`default_nettype wire
